// ----- hdl/hbs_pkg.sv -----
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared sizes, codes and controller/datapath interface types for the
// heightmap bilinear sampler.
// ----------------------------------------------------------------------------
package hbs_pkg;

	localparam int GRID_W    = 128;
	localparam int GRID_H    = 128;
	localparam int FRAC_BITS = 8;

	localparam int COORD_W  = 16;
	localparam int HEIGHT_W = 16;
	localparam int INT_W    = COORD_W - FRAC_BITS;
	localparam int IX_W     = INT_W + 1;
	localparam int DEPTH    = GRID_W * GRID_H;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int PROD_W   = HEIGHT_W + 2 + FRAC_BITS;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 16;

	// request kinds carried in s_tuser
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// neighbor selects for the read address
	localparam logic [1:0] NB_C0R0 = 2'd0;
	localparam logic [1:0] NB_C1R0 = 2'd1;
	localparam logic [1:0] NB_C0R1 = 2'd2;
	localparam logic [1:0] NB_C1R1 = 2'd3;

	// blend steps
	localparam logic [1:0] BL_ROW0 = 2'd0;
	localparam logic [1:0] BL_ROW1 = 2'd1;
	localparam logic [1:0] BL_COL  = 2'd2;

	typedef struct packed {
		logic       latch;
		logic       wr_en;
		logic [1:0] rd_sel;
		logic       cap_en;
		logic [1:0] cap_sel;
		logic       blend_en;
		logic [1:0] blend_sel;
		logic       out_load;
	} hbs_cmd_t;

	typedef struct packed {
		logic is_sample;
		logic in_grid;
	} hbs_sts_t;

endpackage

// ----- hdl/hbs_ram.sv -----
// ----------------------------------------------------------------------------
// hbs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module hbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/hbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// hbs_ctrl
// Sequencer: accepts one word, then steps through write, or four cell
// reads and three blend steps, skipped off grid; owns the output valid.
// ----------------------------------------------------------------------------
module hbs_ctrl
	import hbs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  hbs_sts_t sts,
	output hbs_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DEC  = 4'd1;
	localparam logic [3:0] ST_RD0  = 4'd2;
	localparam logic [3:0] ST_RD1  = 4'd3;
	localparam logic [3:0] ST_RD2  = 4'd4;
	localparam logic [3:0] ST_RD3  = 4'd5;
	localparam logic [3:0] ST_CAP3 = 4'd6;
	localparam logic [3:0] ST_BL1  = 4'd7;
	localparam logic [3:0] ST_BL2  = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0] state_q, state_d;
	logic       mvalid_q;
	logic       out_free;

	assign out_free = !mvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = mvalid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DEC;
				end
			end
			ST_DEC: begin
				if (!sts.is_sample) begin
					cmd.wr_en = sts.in_grid;
					state_d   = ST_IDLE;
				end else if (!sts.in_grid) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_RD0;
				end
			end
			ST_RD0: begin
				cmd.rd_sel = NB_C0R0;
				state_d    = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_sel  = NB_C1R0;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_C0R0;
				state_d     = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_sel  = NB_C0R1;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_C1R0;
				state_d     = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd_sel  = NB_C1R1;
				cmd.cap_en  = 1'b1;
				cmd.cap_sel = NB_C0R1;
				state_d     = ST_CAP3;
			end
			ST_CAP3: begin
				// lower row cells are already held, blend them now
				cmd.cap_en    = 1'b1;
				cmd.cap_sel   = NB_C1R1;
				cmd.blend_en  = 1'b1;
				cmd.blend_sel = BL_ROW0;
				state_d       = ST_BL1;
			end
			ST_BL1: begin
				cmd.blend_en  = 1'b1;
				cmd.blend_sel = BL_ROW1;
				state_d       = ST_BL2;
			end
			ST_BL2: begin
				cmd.blend_en  = 1'b1;
				cmd.blend_sel = BL_COL;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				mvalid_q <= 1'b1;
			end else if (m_tready) begin
				mvalid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/hbs_dp.sv -----
// ----------------------------------------------------------------------------
// hbs_dp
// Datapath: request registers, cell address generation, height RAM,
// neighbor cell registers, shared lerp unit and output register.
// ----------------------------------------------------------------------------
module hbs_dp
	import hbs_pkg::*;
(
	input  logic                clk,
	input  hbs_cmd_t            cmd,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [0:0]          s_tuser,
	output hbs_sts_t            sts,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic [0:0]          m_tuser
);

	logic [COORD_W-1:0]  px_q, py_q;
	logic [HEIGHT_W-1:0] hin_q;
	logic                kind_q;

	logic [INT_W-1:0]    col, row;
	logic [IX_W-1:0]     col_p1, row_p1, col1, row1, cx, ry;
	logic                in_grid;
	logic [ADDR_W-1:0]   waddr, raddr;
	logic [HEIGHT_W-1:0] rdata;

	logic [HEIGHT_W-1:0] cell_q [4];
	logic [HEIGHT_W-1:0] h1_q, h2_q, hf_q;

	logic [HEIGHT_W-1:0]        ba, bb, bsum;
	logic [FRAC_BITS-1:0]       bf;
	logic signed [HEIGHT_W:0]   diff;
	logic signed [FRAC_BITS:0]  fs;
	logic signed [PROD_W-1:0]   prod, quo;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			px_q   <= s_tdata[COORD_W-1:0];
			py_q   <= s_tdata[2*COORD_W-1:COORD_W];
			hin_q  <= s_tdata[2*COORD_W+HEIGHT_W-1:2*COORD_W];
			kind_q <= s_tuser[0];
		end
	end

	assign col     = px_q[COORD_W-1:FRAC_BITS];
	assign row     = py_q[COORD_W-1:FRAC_BITS];
	assign in_grid = (32'(col) < 32'(GRID_W)) && (32'(row) < 32'(GRID_H));

	assign sts.is_sample = (kind_q == REQ_SAMPLE);
	assign sts.in_grid   = in_grid;

	// clamp the right and upper neighbors at the grid edge
	assign col_p1 = IX_W'(col) + IX_W'(1);
	assign row_p1 = IX_W'(row) + IX_W'(1);
	assign col1   = (32'(col_p1) < 32'(GRID_W)) ? col_p1 : IX_W'(GRID_W - 1);
	assign row1   = (32'(row_p1) < 32'(GRID_H)) ? row_p1 : IX_W'(GRID_H - 1);

	always_comb begin
		case (cmd.rd_sel)
			NB_C0R0: begin cx = IX_W'(col); ry = IX_W'(row); end
			NB_C1R0: begin cx = col1;       ry = IX_W'(row); end
			NB_C0R1: begin cx = IX_W'(col); ry = row1;       end
			NB_C1R1: begin cx = col1;       ry = row1;       end
			default: begin cx = IX_W'(col); ry = IX_W'(row); end
		endcase
	end

	assign raddr = ADDR_W'(32'(ry) * 32'(GRID_W) + 32'(cx));
	assign waddr = ADDR_W'(32'(row) * 32'(GRID_W) + 32'(col));

	hbs_ram #(
		.WIDTH(HEIGHT_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(waddr),
		.wdata(hin_q),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_en) begin
			cell_q[cmd.cap_sel] <= rdata;
		end
	end

	// lerp: a + floor(f * (b - a) / 2^FRAC_BITS); result stays between a and b
	always_comb begin
		case (cmd.blend_sel)
			BL_ROW0: begin
				ba = cell_q[0];
				bb = cell_q[1];
				bf = px_q[FRAC_BITS-1:0];
			end
			BL_ROW1: begin
				ba = cell_q[2];
				bb = cell_q[3];
				bf = px_q[FRAC_BITS-1:0];
			end
			BL_COL: begin
				ba = h1_q;
				bb = h2_q;
				bf = py_q[FRAC_BITS-1:0];
			end
			default: begin
				ba = h1_q;
				bb = h2_q;
				bf = py_q[FRAC_BITS-1:0];
			end
		endcase
	end

	assign diff = $signed({bb[HEIGHT_W-1], bb}) - $signed({ba[HEIGHT_W-1], ba});
	assign fs   = $signed({1'b0, bf});
	assign prod = PROD_W'(diff) * PROD_W'(fs);
	assign quo  = prod >>> FRAC_BITS;
	assign bsum = ba + quo[HEIGHT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.blend_en) begin
			case (cmd.blend_sel)
				BL_ROW0: h1_q <= bsum;
				BL_ROW1: h2_q <= bsum;
				BL_COL:  hf_q <= bsum;
				default: hf_q <= bsum;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata    <= in_grid ? hf_q : '0;
			m_tuser[0] <= in_grid;
		end
	end

endmodule

// ----- hdl/heightmap_bilinear_sampler_unit.sv -----
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler_unit
// Sample in grid: after accept, decode, four serial reads of the single read
// port of the height RAM and three blend steps, then output load; the next
// word is taken only after that. Sample outside grid: decode, output load.
// Write: decode. The output register lets a new word in while a result waits.
// arst_n clears the sequencer and output valid; grid contents are not cleared.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler_unit
	import hbs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // pos_x, pos_y, height_in
	input  logic [0:0]          s_tuser,  // req_type
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // height_out
	output logic [0:0]          m_tuser   // in_map
);

	hbs_cmd_t cmd;
	hbs_sts_t sts;

	hbs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	hbs_dp u_dp (
		.clk    (clk),
		.cmd    (cmd),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.sts    (sts),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result loaded over an untaken word");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word taken while one is in progress");

	a_write_legal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (sts.in_grid && !sts.is_sample))
		else $error("RAM write outside grid or on a sample");

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
		else $error("out-of-grid result is not zero");

endmodule
